// ===== rtl/cbd_pkg.sv =====
// Shared types, codes and helpers for the chunked body decoder.
package cbd_pkg;

  // Default width of the chunk size counter
  localparam int unsigned SIZE_BITS_DEF = 32;

  // Byte codes
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  // Error codes
  typedef logic [2:0] err_t;
  localparam err_t ERR_NONE     = 3'd0;
  localparam err_t ERR_SIZE_LF  = 3'd1;
  localparam err_t ERR_DATA_CR  = 3'd2;
  localparam err_t ERR_DATA_LF  = 3'd3;
  localparam err_t ERR_HEX      = 3'd4;
  localparam err_t ERR_OVERFLOW = 3'd5;

  // Parse phases, one-hot
  typedef enum logic [4:0] {
    PH_SIZE    = 5'b00001,
    PH_SIZE_LF = 5'b00010,
    PH_DATA    = 5'b00100,
    PH_DATA_CR = 5'b01000,
    PH_DATA_LF = 5'b10000
  } phase_t;

  // One decoded result
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       end_of_body;
    err_t       error_code;
  } result_t;

  // Decode an ASCII hex digit: bit 4 set marks a valid digit, bits 3:0 its value
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== rtl/cbd_parser.sv =====
// Chunk framing state and the per-byte parse step.
module cbd_parser #(
  parameter int unsigned SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       in_byte,
  output cbd_pkg::result_t res
);
  import cbd_pkg::*;

  phase_t               phase, phase_next;
  logic [SIZE_BITS-1:0] remaining, remaining_next;
  logic                 last_chunk, last_chunk_next;
  err_t                 sticky, sticky_next;

  logic [SIZE_BITS-1:0] dec;
  logic [4:0]           hex;

  assign dec = remaining - {{(SIZE_BITS-1){1'b0}}, 1'b1};
  assign hex = hex_digit(in_byte);

  // Compute the next state and the result for the byte at hand
  always_comb begin
    phase_next      = phase;
    remaining_next  = remaining;
    last_chunk_next = last_chunk;
    sticky_next     = sticky;
    res             = '0;
    if (sticky == ERR_NONE) begin
      unique case (phase)
        PH_SIZE_LF: begin
          if (in_byte == BYTE_LF) begin
            if (remaining != '0) begin
              phase_next = PH_DATA;
            end else begin
              phase_next      = PH_DATA_CR;
              last_chunk_next = 1'b1;
            end
          end else begin
            sticky_next = ERR_SIZE_LF;
          end
        end
        PH_DATA: begin
          res.payload_valid = 1'b1;
          res.payload_byte  = in_byte;
          remaining_next    = dec;
          if (dec == '0) phase_next = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (in_byte == BYTE_CR) phase_next = PH_DATA_LF;
          else sticky_next = ERR_DATA_CR;
        end
        PH_DATA_LF: begin
          if (in_byte == BYTE_LF) begin
            res.end_of_body = last_chunk;
            last_chunk_next = 1'b0;
            remaining_next  = '0;
            phase_next      = PH_SIZE;
          end else begin
            sticky_next = ERR_DATA_LF;
          end
        end
        default: begin
          // Size digits; unreachable codes behave the same
          if (in_byte == BYTE_CR) begin
            phase_next = PH_SIZE_LF;
          end else if (!hex[4]) begin
            sticky_next = ERR_HEX;
          end else if (remaining[SIZE_BITS-1 -: 4] != 4'd0) begin
            sticky_next = ERR_OVERFLOW;
          end else begin
            remaining_next = {remaining[SIZE_BITS-5:0], hex[3:0]};
            phase_next     = PH_SIZE;
          end
        end
      endcase
    end
    res.error_code = sticky_next;
  end

  // Advance the parse state once per byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SIZE;
      remaining  <= '0;
      last_chunk <= 1'b0;
      sticky     <= ERR_NONE;
    end else if (step) begin
      phase      <= phase_next;
      remaining  <= remaining_next;
      last_chunk <= last_chunk_next;
      sticky     <= sticky_next;
    end
  end

endmodule

// ===== rtl/http_chunked_body_decoder.sv =====
// Top level of the chunked HTTP body decoder: input register, parser, result register.
//
// Usage: raw body bytes enter on the slave stream (s_tdata), one byte per
// transaction. Every byte yields exactly one result transaction on the
// master stream: m_tuser flags a payload byte in m_tdata[7:0], m_tlast
// marks the LF that closes the zero-size chunk (end of body), and
// m_tdata[10:8] carries the error code, which stays set until reset.
// Each byte passes through the input register and then the result register
// before its result transaction appears.
// Throughput is one byte per cycle while m_tready is high; the parse
// step is a single pass of logic between the two registers, bounded by
// the size counter's decrement and shift-in path.
// Reset empties both registers and returns the parser to the size digits
// phase with no error. When the receiver holds m_tready low, the result
// register keeps its transaction, one more byte waits in the input
// register, and s_tready then drops until the result is taken.
module http_chunked_body_decoder #(
  parameter int unsigned SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] payload_byte, [10:8] error_code, [15:11] zero
  output logic        m_tuser,   // [0] payload_valid
  output logic        m_tlast    // end_of_body
);
  import cbd_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_valid;
  result_t    out_res;
  result_t    res;
  logic       advance;

  // Move the held byte forward when the result register is free
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  cbd_parser #(
    .SIZE_BITS(SIZE_BITS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .in_byte (in_byte),
    .res     (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  // Drive the master stream
  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_res.error_code, out_res.payload_byte};
  assign m_tuser  = out_res.payload_valid;
  assign m_tlast  = out_res.end_of_body;

endmodule
